// ===== design/ttrb_pkg.sv =====
// Shared constants, types and helpers for the timed trail ring buffer.
package ttrb_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam logic [31:0] FadeInMs     = 32'd200;
  localparam logic [8:0]  Opaque       = 9'd256;

  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdUpdate = 2'd1,
    CmdRead   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  // One trail entry: timestamp and position.
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } entry_t;

  // Saturating difference: zero when a < b.
  function automatic logic [31:0] diff_sat(input logic [31:0] a, input logic [31:0] b);
    return (a >= b) ? (a - b) : 32'd0;
  endfunction

endpackage

// ===== design/ttrb_ram.sv =====
// Generic single write, single read RAM with registered read data.
module ttrb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/ttrb_div_cell.sv =====
// One restoring-division cell: takes one quotient bit and hands the rest on.
module ttrb_div_cell (
  input  logic        clk_i,
  input  logic [40:0] rem_i,
  input  logic        bit_i,
  input  logic [31:0] div_i,
  input  logic [8:0]  quo_i,
  output logic [40:0] rem_o,
  output logic [31:0] div_o,
  output logic [8:0]  quo_o
);

  logic [41:0] shifted;
  logic        take;

  always_comb begin
    // shift in the next numerator bit
    shifted = {rem_i, bit_i};
    take    = (shifted[41:32] != 10'd0) || (shifted[31:0] >= div_i);
  end

  always_ff @(posedge clk_i) begin
    div_o <= div_i;
    quo_o <= {quo_i[7:0], take};
    rem_o <= take ? (shifted[40:0] - {9'd0, div_i}) : shifted[40:0];
  end

endmodule

// ===== design/timed_trail_ring_buffer.sv =====
// Top level of the timed trail ring buffer.
//
// Keeps one particle's trail as a ring of timestamped Q16.16 positions.
// Input channel in_valid_i/in_ready_o carries one command word (start,
// update, read); each accepted word gives exactly one result word on
// out_valid_o/out_ready_i. The user must write the trail time register through
// cfg_valid_i/cfg_ready_o only while the block is idle; it is not enforced.
//
// One word at a time. An update of a live particle walks the tail and drops each
// expired entry, reading the timestamp RAM one entry per pass. The opacity
// quotient comes from a row of nine division cells that pass the partial
// remainder along in every cycle.
//
// Reset clears the flags and indices; the trail RAM holds garbage until
// written, and only written entries are ever reported. A stalled receiver
// holds the result register and blocks the input; the next word is taken
// at the earliest in the cycle after the result word is accepted.
module timed_trail_ring_buffer #(
  parameter int unsigned TrailDepth = ttrb_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0] lifetime_ms_i,
  input  logic [5:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        alive_o,
  output logic        dying_o,
  output logic [5:0]  live_count_o,
  output logic [31:0] elapsed_ms_o,
  output logic [8:0]  opacity_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        entry_valid_o
);
  import ttrb_pkg::*;

  localparam int unsigned Aw = $clog2(TrailDepth);
  localparam int unsigned NumCells = 9;

  typedef enum logic [3:0] {
    StIdle, StApply, StTailRd, StTailWait, StTailChk, StDiv, StDivWait, StReadWait,
    StOut
  } state_e;

  state_e state_q;
  logic [31:0] trail_q;
  logic alive_q, dying_q;
  logic [Aw-1:0] head_q, tail_q;
  logic [31:0] birth_q, due_q, began_q, last_q;
  logic [1:0]  cmd_q;
  logic [31:0] now_q, px_q, py_q, pz_q, life_q;
  logic [5:0]  idx_q;
  logic [31:0] elapsed_q;
  logic        first_q;
  logic        show_q, valid_q;
  logic [3:0]  cnt_q;
  logic        full_q;

  // RAM port control
  logic          we;
  logic [Aw-1:0] waddr, raddr_q;
  entry_t        wdata, rdata;

  // live count in ring arithmetic
  logic [Aw:0] live_cnt;
  always_comb begin
    if (!alive_q) begin
      live_cnt = '0;
    end else if (head_q >= tail_q) begin
      live_cnt = {1'b0, head_q} - {1'b0, tail_q};
    end else begin
      live_cnt = {1'b0, head_q} + (Aw+1)'(TrailDepth) - {1'b0, tail_q};
    end
  end

  function automatic logic [Aw-1:0] nxt(input logic [Aw-1:0] i);
    return ({1'b0, i} + 1'b1 >= (Aw+1)'(TrailDepth)) ? '0 : i + 1'b1;
  endfunction

  logic [Aw-1:0] newest;
  assign newest = (head_q == '0) ? Aw'(TrailDepth - 1) : head_q - 1'b1;

  // Append decision, tail after a full-ring drop, and read slot with wrap
  logic          append;
  logic [Aw-1:0] upd_tail;
  logic [Aw:0]   rd_sum;
  logic [Aw-1:0] rd_addr;
  always_comb begin
    append   = alive_q && !dying_q && !(now_q >= due_q);
    upd_tail = (append && live_cnt >= (Aw+1)'(TrailDepth - 1)) ? nxt(tail_q) : tail_q;
    rd_sum   = {1'b0, tail_q} + (Aw+1)'(idx_q);
    rd_addr  = (rd_sum >= (Aw+1)'(TrailDepth)) ? Aw'(rd_sum - (Aw+1)'(TrailDepth))
                                               : Aw'(rd_sum);
  end

  ttrb_ram #(.Width($bits(entry_t)), .Depth(TrailDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  // division chain: numerator*256 / denominator
  logic [40:0] rem   [NumCells+1];
  logic [31:0] divr  [NumCells+1];
  logic [8:0]  quo   [NumCells+1];
  logic [40:0] num_q;
  logic [31:0] den_q;

  assign rem[0]  = num_q >> 9;
  assign divr[0] = den_q;
  assign quo[0]  = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    ttrb_div_cell u_cell (
      .clk_i (clk_i),
      .rem_i (rem[g]),
      .bit_i (num_q[8-g]),
      .div_i (divr[g]),
      .quo_i (quo[g]),
      .rem_o (rem[g+1]),
      .div_o (divr[g+1]),
      .quo_o (quo[g+1])
    );
  end

  // Opacity operands and special cases
  logic [31:0] d_in, d_out;
  logic        op_zero, op_full;
  always_comb begin
    d_in    = diff_sat(last_q, birth_q);
    d_out   = diff_sat(last_q, began_q);
    op_zero = !alive_q || (dying_q && (trail_q == '0 || d_out > trail_q));
    op_full = alive_q && !dying_q && (d_in >= FadeInMs);
  end

  logic [31:0] tail_age;
  assign tail_age = diff_sat(now_q, rdata.t);

  always_comb begin
    we      = 1'b0;
    waddr   = head_q;
    wdata   = '{t: now_q, x: px_q, y: py_q, z: pz_q};
    if (state_q == StApply) begin
      if (cmd_q == CmdStart) begin
        we    = 1'b1;
        waddr = '0;
      end else if (cmd_q == CmdUpdate && append) begin
        we = 1'b1;
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle) && !out_valid_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      trail_q       <= '0;
      alive_q       <= 1'b0;
      dying_q       <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      birth_q       <= '0;
      due_q         <= '0;
      began_q       <= '0;
      last_q        <= '0;
      out_valid_o   <= 1'b0;
      raddr_q       <= '0;
      cnt_q         <= '0;
      cmd_q         <= CmdNone;
      first_q       <= 1'b0;
      show_q        <= 1'b0;
      valid_q       <= 1'b0;
      full_q        <= 1'b0;
      elapsed_q     <= '0;
      num_q         <= '0;
      den_q         <= '0;
      now_q         <= '0;
      px_q          <= '0;
      py_q          <= '0;
      pz_q          <= '0;
      life_q        <= '0;
      idx_q         <= '0;
      alive_o       <= 1'b0;
      dying_o       <= 1'b0;
      live_count_o  <= '0;
      elapsed_ms_o  <= '0;
      opacity_o     <= '0;
      out_x_o       <= '0;
      out_y_o       <= '0;
      out_z_o       <= '0;
      entry_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        trail_q <= cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q   <= cmd_i;
            now_q   <= now_ms_i;
            px_q    <= pos_x_i;
            py_q    <= pos_y_i;
            pz_q    <= pos_z_i;
            life_q  <= lifetime_ms_i;
            idx_q   <= entry_index_i;
            state_q <= StApply;
          end
        end
        StApply: begin
          elapsed_q <= '0;
          case (cmd_q)
            CmdStart: begin
              alive_q <= 1'b1;
              dying_q <= 1'b0;
              due_q   <= (now_q > ~life_q) ? 32'hFFFF_FFFF : now_q + life_q;
              birth_q <= now_q;
              tail_q  <= '0;
              head_q  <= Aw'(1);
              raddr_q <= '0;
              show_q  <= 1'b1;
              valid_q <= 1'b0;
              state_q <= StReadWait;
            end
            CmdUpdate: begin
              valid_q <= 1'b0;
              show_q  <= 1'b0;
              if (!alive_q) begin
                state_q <= StDiv;
              end else begin
                last_q <= now_q;
                if (!dying_q && now_q >= due_q) begin
                  began_q <= now_q;
                  dying_q <= 1'b1;
                end else if (!dying_q) begin
                  head_q <= nxt(head_q);
                end
                // drop the oldest entry first when the ring is full
                tail_q  <= upd_tail;
                raddr_q <= upd_tail;
                first_q <= 1'b1;
                state_q <= StTailRd;
              end
            end
            CmdRead: begin
              if (alive_q && 32'(idx_q) < 32'(live_cnt)) begin
                raddr_q <= rd_addr;
                show_q  <= 1'b1;
                valid_q <= 1'b1;
                state_q <= StReadWait;
              end else begin
                show_q  <= 1'b0;
                valid_q <= 1'b0;
                state_q <= StDiv;
              end
            end
            default: begin
              raddr_q <= newest;
              show_q  <= alive_q;
              valid_q <= 1'b0;
              state_q <= StReadWait;
            end
          endcase
        end
        StTailRd: begin
          // RAM read of tail issued; data lands next cycle
          state_q <= StTailWait;
        end
        StTailWait: begin
          state_q <= StTailChk;
        end
        StTailChk: begin
          if (first_q) begin
            elapsed_q <= tail_age;
            first_q   <= 1'b0;
          end
          if (tail_q != head_q && tail_age > trail_q) begin
            tail_q  <= nxt(tail_q);
            raddr_q <= nxt(tail_q);
            state_q <= StTailRd;
          end else begin
            if (dying_q && tail_q == head_q) begin
              alive_q <= 1'b0;
            end
            raddr_q <= newest;
            show_q  <= !(dying_q && tail_q == head_q);
            state_q <= StReadWait;
          end
        end
        StReadWait: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (dying_q) begin
            num_q <= {(trail_q - d_out), 9'd0} >> 1;
            den_q <= trail_q;
          end else begin
            num_q <= {d_in, 9'd0} >> 1;
            den_q <= FadeInMs;
          end
          full_q  <= op_full;
          cnt_q   <= '0;
          state_q <= StDivWait;
        end
        StDivWait: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(NumCells)) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          alive_o       <= alive_q;
          dying_o       <= dying_q;
          live_count_o  <= 6'(live_cnt);
          elapsed_ms_o  <= elapsed_q;
          opacity_o     <= op_zero ? 9'd0 : (full_q ? Opaque : quo[NumCells]);
          out_x_o       <= show_q ? rdata.x : '0;
          out_y_o       <= show_q ? rdata.y : '0;
          out_z_o       <= show_q ? rdata.z : '0;
          entry_valid_o <= valid_q;
          out_valid_o   <= 1'b1;
          state_q       <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/ttrb_checker.sv =====
// Port-level checker for the timed trail ring buffer, bound to the top level.
module ttrb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       alive_o,
  input logic [5:0] live_count_o,
  input logic [8:0] opacity_o,
  input logic       entry_valid_o
);

  // a result waiting must hold until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_dead_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !alive_o |-> live_count_o == 6'd0 && opacity_o == 9'd0
      && !entry_valid_o)
    else $error("dead particle reports trail");

  a_opacity_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> opacity_o <= 9'd256)
    else $error("opacity out of range");

endmodule

bind timed_trail_ring_buffer ttrb_checker u_ttrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .alive_o       (alive_o),
  .live_count_o  (live_count_o),
  .opacity_o     (opacity_o),
  .entry_valid_o (entry_valid_o)
);
